// File: src/ecls_pkg.sv
// ---------------------------------------------------------------------------
// ecls_pkg
// Shared types and constants of the Ethernet receive frame classifier.
// ---------------------------------------------------------------------------
package ecls_pkg;

  localparam int BUFFER_BYTES = 2048;
  // byte counter holds the buffer size itself
  localparam int CNT_W = $clog2(BUFFER_BYTES) + 1;
  // echo sum: at most one 16-bit word per two buffered bytes
  localparam int SUM_W = $clog2(BUFFER_BYTES) + 15;

  localparam int ETH_HDR_BYTES  = 14;
  localparam int IP_MIN_HDR     = 20;
  localparam int IP_SRC_FIRST   = 26;
  localparam int ARP_MIN_FRAME  = 42;
  localparam int L4_FIRST_POS   = 34;
  localparam int ICMP_HDR_SKIP  = 4;
  localparam int ICMP_MIN_LEN   = 8;
  localparam int ECHO_MAX_LEN   = 1500;

  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  localparam logic [2:0] VERDICT_DROP      = 3'd0;
  localparam logic [2:0] VERDICT_ARP_REPLY = 3'd1;
  localparam logic [2:0] VERDICT_ARP_REQ   = 3'd2;
  localparam logic [2:0] VERDICT_ECHO      = 3'd3;
  localparam logic [2:0] VERDICT_DELIVER   = 3'd4;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [7:0]  protocol;
    logic [6:0]  l4_offset;
    logic [10:0] l4_length;
    logic [15:0] echo_checksum;
    logic        cache_valid;
    logic [31:0] cache_ip;
    logic [47:0] cache_mac;
  } out_t;

  // header fields of one complete frame, handed from the parser to the judge
  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [15:0]      ether_type;
    logic [15:0]      arp_operation;
    logic [47:0]      arp_sender_mac;
    logic [31:0]      arp_sender_ip;
    logic [31:0]      arp_target_ip;
    logic [7:0]       ip_version_ihl;
    logic [15:0]      ip_total_length;
    logic [7:0]       ip_protocol;
    logic [31:0]      ip_source;
    logic [7:0]       l4_first_byte;
    logic [SUM_W-1:0] sum_accumulator;
  } frame_sum_t;

endpackage

// File: src/ecls_parse.sv
// ---------------------------------------------------------------------------
// ecls_parse
// Byte-wise header capture and echo body summing for the frame in progress.
// ---------------------------------------------------------------------------
module ecls_parse import ecls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_t        in_byte,
  output frame_sum_t summary
);

  logic [CNT_W-1:0] byte_count;
  logic [15:0]      ether_type;
  logic [15:0]      arp_operation;
  logic [47:0]      arp_sender_mac;
  logic [31:0]      arp_sender_ip;
  logic [31:0]      arp_target_ip;
  logic [7:0]       ip_version_ihl;
  logic [15:0]      ip_total_length;
  logic [7:0]       ip_protocol;
  logic [31:0]      ip_source;
  logic [7:0]       l4_first_byte;
  logic [SUM_W-1:0] sum_accumulator;

  logic [CNT_W-1:0] p;
  logic [7:0]       b;
  logic             keep;
  logic [5:0]       ihl;
  logic [CNT_W-1:0] l4_start;
  logic [CNT_W-1:0] k;
  logic             in_l4;
  logic             in_body;
  logic [SUM_W-1:0] term;

  frame_sum_t nxt;

  assign p    = byte_count;
  assign b    = in_byte.frame_byte;
  assign keep = (byte_count < CNT_W'(BUFFER_BYTES));
  assign ihl  = {ip_version_ihl[3:0], 2'b00};
  assign l4_start = CNT_W'(ETH_HDR_BYTES) + CNT_W'(ihl);
  assign k    = p - l4_start;

  assign in_l4 = (p >= CNT_W'(L4_FIRST_POS)) && (ihl >= 6'(IP_MIN_HDR)) && (p >= l4_start);
  assign in_body = in_l4 && (k >= CNT_W'(ICMP_HDR_SKIP))
                && (ip_total_length >= 16'(ihl))
                && (16'(k) < (ip_total_length - 16'(ihl)));
  // even body offsets carry the high byte of a word
  assign term = k[0] ? SUM_W'(b) : SUM_W'({b, 8'h00});

  always_comb begin
    nxt.byte_count      = byte_count;
    nxt.ether_type      = ether_type;
    nxt.arp_operation   = arp_operation;
    nxt.arp_sender_mac  = arp_sender_mac;
    nxt.arp_sender_ip   = arp_sender_ip;
    nxt.arp_target_ip   = arp_target_ip;
    nxt.ip_version_ihl  = ip_version_ihl;
    nxt.ip_total_length = ip_total_length;
    nxt.ip_protocol     = ip_protocol;
    nxt.ip_source       = ip_source;
    nxt.l4_first_byte   = l4_first_byte;
    nxt.sum_accumulator = sum_accumulator;
    if (keep) begin
      nxt.byte_count = byte_count + CNT_W'(1);
      if (p == CNT_W'(12) || p == CNT_W'(13)) begin
        nxt.ether_type = {ether_type[7:0], b};
      end
      if (p == CNT_W'(20) || p == CNT_W'(21)) begin
        nxt.arp_operation = {arp_operation[7:0], b};
      end
      if (p >= CNT_W'(22) && p <= CNT_W'(27)) begin
        nxt.arp_sender_mac = {arp_sender_mac[39:0], b};
      end
      if (p >= CNT_W'(28) && p <= CNT_W'(31)) begin
        nxt.arp_sender_ip = {arp_sender_ip[23:0], b};
      end
      if (p >= CNT_W'(38) && p <= CNT_W'(41)) begin
        nxt.arp_target_ip = {arp_target_ip[23:0], b};
      end
      if (p == CNT_W'(ETH_HDR_BYTES)) begin
        nxt.ip_version_ihl = b;
      end
      if (p == CNT_W'(16) || p == CNT_W'(17)) begin
        nxt.ip_total_length = {ip_total_length[7:0], b};
      end
      if (p == CNT_W'(23)) begin
        nxt.ip_protocol = b;
      end
      if (p >= CNT_W'(IP_SRC_FIRST) && p <= CNT_W'(IP_SRC_FIRST + 3)) begin
        nxt.ip_source = {ip_source[23:0], b};
      end
      if (in_l4 && k == '0) begin
        nxt.l4_first_byte = b;
      end
      if (in_body) begin
        nxt.sum_accumulator = sum_accumulator + term;
      end
    end
  end

  assign summary = nxt;

  always_ff @(posedge clk) begin
    if (rst || (accept && in_byte.last_byte)) begin
      byte_count      <= '0;
      ether_type      <= '0;
      arp_operation   <= '0;
      arp_sender_mac  <= '0;
      arp_sender_ip   <= '0;
      arp_target_ip   <= '0;
      ip_version_ihl  <= '0;
      ip_total_length <= '0;
      ip_protocol     <= '0;
      ip_source       <= '0;
      l4_first_byte   <= '0;
      sum_accumulator <= '0;
    end else if (accept) begin
      byte_count      <= nxt.byte_count;
      ether_type      <= nxt.ether_type;
      arp_operation   <= nxt.arp_operation;
      arp_sender_mac  <= nxt.arp_sender_mac;
      arp_sender_ip   <= nxt.arp_sender_ip;
      arp_target_ip   <= nxt.arp_target_ip;
      ip_version_ihl  <= nxt.ip_version_ihl;
      ip_total_length <= nxt.ip_total_length;
      ip_protocol     <= nxt.ip_protocol;
      ip_source       <= nxt.ip_source;
      l4_first_byte   <= nxt.l4_first_byte;
      sum_accumulator <= nxt.sum_accumulator;
    end
  end

endmodule

// File: src/ethernet_rx_frame_classifier_top.sv
// ---------------------------------------------------------------------------
// ethernet_rx_frame_classifier_top
// Classifies received Ethernet frames (ARP, ICMP echo, IPv4) one byte per
// cycle while in_stall is low and keeps a single ARP cache entry.
// ---------------------------------------------------------------------------
//  channel | signals                          | transaction
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data      | one frame byte and last flag
//  out     | out_valid, out_stall, out_data   | one verdict per frame
//  cfg     | cfg_write, cfg_data              | write of local_ip
//
//  one byte is taken every cycle unless in_stall is high; after the last byte
//  a verdict passes the frame summary register, then the judge into the result register.
//  synchronous reset clears the frame state, the arp cache and local_ip.
//  in_stall rises only when a finished frame waits in the summary register and
//  the result register is stalled; mid-frame bytes are then held too.
// ---------------------------------------------------------------------------
module ethernet_rx_frame_classifier_top import ecls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  logic [31:0] local_ip;
  logic        in_accept;
  logic        out_load;
  frame_sum_t  summary;
  frame_sum_t  snap;
  logic        snap_valid;

  logic        entry_valid;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic        entry_load;

  out_t             result;
  logic [5:0]       ihl;
  logic [6:0]       l4_off;
  logic [CNT_W-1:0] avail;
  logic [15:0]      l4len_full;
  logic [15:0]      l4len;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = snap_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  ecls_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .in_byte (in_data),
    .summary (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg_write) begin
      local_ip <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_accept && in_data.last_byte) begin
      snap_valid <= 1'b1;
    end else if (out_load) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      snap <= summary;
    end
  end

  assign ihl        = {snap.ip_version_ihl[3:0], 2'b00};
  assign l4_off     = 7'(ETH_HDR_BYTES) + 7'(ihl);
  assign avail      = snap.byte_count - CNT_W'(l4_off);
  assign l4len_full = snap.ip_total_length - 16'(ihl);
  assign l4len      = (l4len_full > 16'(avail)) ? 16'(avail) : l4len_full;
  // end-around carry, two folds cover the whole sum
  assign fold1 = 17'(snap.sum_accumulator[15:0]) + 17'(snap.sum_accumulator[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    result     = '0;
    entry_load = 1'b0;
    if (snap.byte_count < CNT_W'(ETH_HDR_BYTES)) begin
      result.verdict = VERDICT_DROP;
    end else if (snap.ether_type == ETH_TYPE_ARP) begin
      if (snap.byte_count >= CNT_W'(ARP_MIN_FRAME)) begin
        if (snap.arp_operation == ARP_OP_REPLY) begin
          entry_load     = 1'b1;
          result.verdict = VERDICT_ARP_REPLY;
        end else if (snap.arp_operation == ARP_OP_REQUEST && local_ip != '0
                     && snap.arp_target_ip == local_ip) begin
          result.verdict = VERDICT_ARP_REQ;
        end
      end
      if (result.verdict != VERDICT_DROP) begin
        result.peer_ip  = snap.arp_sender_ip;
        result.peer_mac = snap.arp_sender_mac;
      end
    end else if (snap.ether_type == ETH_TYPE_IPV4) begin
      if (snap.ip_version_ihl[7:4] == IP_VERSION_4 && ihl >= 6'(IP_MIN_HDR)
          && snap.ip_total_length >= 16'(ihl)
          && snap.byte_count >= CNT_W'(l4_off)) begin
        if (snap.ip_protocol == IP_PROTO_ICMP && l4len >= 16'(ICMP_MIN_LEN)
            && snap.l4_first_byte == ICMP_ECHO_REQUEST) begin
          if (l4len <= 16'(ECHO_MAX_LEN)) begin
            result.verdict       = VERDICT_ECHO;
            result.peer_ip       = snap.ip_source;
            result.echo_checksum = ~fold2;
          end
        end else begin
          result.verdict   = VERDICT_DELIVER;
          result.peer_ip   = snap.ip_source;
          result.protocol  = snap.ip_protocol;
          result.l4_offset = l4_off;
          result.l4_length = l4len[10:0];
        end
      end
    end
    result.cache_valid = entry_load ? 1'b1 : entry_valid;
    result.cache_ip    = entry_load ? snap.arp_sender_ip : entry_ip;
    result.cache_mac   = entry_load ? snap.arp_sender_mac : entry_mac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      entry_ip    <= '0;
      entry_mac   <= '0;
    end else if (snap_valid && out_load && entry_load) begin
      entry_valid <= 1'b1;
      entry_ip    <= snap.arp_sender_ip;
      entry_mac   <= snap.arp_sender_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && snap_valid) begin
      out_data <= result;
    end
  end

endmodule
